>>> rtl/arv3_pkg.sv
//------------------------------------------------------------------------------
// arv3_pkg
// Shared types, widths and constants for the axis rotation pipeline.
//------------------------------------------------------------------------------
package arv3_pkg;

    // Defaults for the top-level parameters
    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Fixed widths
    localparam int COORD_W    = 32;              // point coordinates and angle
    localparam int TRIG_W     = 33;              // CORDIC x/y, Q2.30 with headroom
    localparam int ANG_W      = 41;              // residual angle, 2^-32 degree units
    localparam int ANG_FRAC   = 32;              // fraction bits of the residual angle
    localparam int TRIG_SHIFT = 30;              // fraction bits of cos/sin
    localparam int PROD_W     = COORD_W + TRIG_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int WIDE_W     = SUM_W - TRIG_SHIFT;
    localparam int ATAN_LEN   = 24;

    // Reduction modulo 360 = 45 * 8: the factor 8 is taken by the bit split
    localparam int MOD_BASE   = 45;
    localparam int DIGIT_W    = 6;
    localparam int RECIP_W    = 27;
    localparam logic [RECIP_W-1:0] RECIP_45 = 27'd95443718;   // ceil(2^32 / 45)

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic signed [ANG_W-1:0]   ang_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    localparam trig_t  INV_GAIN  = 33'sd652032874;            // 0.6072529350 in Q2.30
    localparam coord_t COORD_MAX = 32'sh7fff_ffff;
    localparam coord_t COORD_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        axis_t  axis;
    } point_t;

    // atan(2^-i) in degrees, scaled by 2^32
    function automatic ang_t atan_deg(input int idx);
        ang_t val;
        case (idx)
            0:       val = 41'sd193273528320;
            1:       val = 41'sd114096026022;
            2:       val = 41'sd60285206653;
            3:       val = 41'sd30601712202;
            4:       val = 41'sd15360239180;
            5:       val = 41'sd7687607525;
            6:       val = 41'sd3844741810;
            7:       val = 41'sd1922488225;
            8:       val = 41'sd961258780;
            9:       val = 41'sd480631223;
            10:      val = 41'sd240315841;
            11:      val = 41'sd120157949;
            12:      val = 41'sd60078978;
            13:      val = 41'sd30039490;
            14:      val = 41'sd15019745;
            15:      val = 41'sd7509872;
            16:      val = 41'sd3754936;
            17:      val = 41'sd1877468;
            18:      val = 41'sd938734;
            19:      val = 41'sd469367;
            20:      val = 41'sd234684;
            21:      val = 41'sd117342;
            22:      val = 41'sd58671;
            23:      val = 41'sd29335;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/arv3_angle.sv
//------------------------------------------------------------------------------
// arv3_angle
// Three-stage angle reduction: modulo 360 degrees, fold into [-90, 90].
//------------------------------------------------------------------------------
module arv3_angle
#(
    parameter int FRAC_BITS = arv3_pkg::FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  arv3_pkg::coord_t in_angle,
    input  arv3_pkg::point_t in_pt,
    output logic             out_valid,
    input  logic             out_ready,
    output arv3_pkg::ang_t   out_z,
    output logic             out_flip,
    output arv3_pkg::point_t out_pt
);
    import arv3_pkg::*;

    localparam int LOW_W  = FRAC_BITS + 3;        // 360 = 45 * 2^3
    localparam int H_W    = COORD_W - LOW_W;
    localparam int P_W    = H_W + RECIP_W + 1;
    localparam int Q_W    = P_W - 32;
    localparam int R_W    = H_W + 2;
    localparam int RED_W  = LOW_W + DIGIT_W;
    localparam int FOLD_W = RED_W + 1;
    localparam int SHIFT  = ANG_FRAC - FRAC_BITS;

    localparam logic [RED_W-1:0]         QUARTER = RED_W'(64'd90 << FRAC_BITS);
    localparam logic [RED_W-1:0]         THREE_Q = RED_W'(64'd270 << FRAC_BITS);
    localparam logic signed [FOLD_W-1:0] HALF_S  = FOLD_W'(64'd180 << FRAC_BITS);
    localparam logic signed [FOLD_W-1:0] FULL_S  = FOLD_W'(64'd360 << FRAC_BITS);

    logic ld1, ld2, ld3;
    logic v1_reg, v2_reg, v3_reg;

    // stage 1: reciprocal multiply of the high part
    logic signed [H_W-1:0] h_next, h1_reg;
    logic signed [P_W-1:0] prod_next, prod_reg;
    logic [LOW_W-1:0]      low1_reg;
    point_t                pt1_reg;

    // stage 2: residue modulo 45
    logic signed [Q_W-1:0] q_s;
    logic signed [R_W-1:0] r_s;
    logic [DIGIT_W-1:0]    digit_next, digit_reg;
    logic [LOW_W-1:0]      low2_reg;
    point_t                pt2_reg;

    // stage 3: fold
    logic [RED_W-1:0]          red;
    logic signed [FOLD_W-1:0]  red_s, fold_s;
    ang_t                      z_next, z_reg;
    logic                      flip_next, flip_reg;
    point_t                    pt3_reg;

    assign ld3      = !v3_reg || out_ready;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    always_comb
    begin
        h_next    = in_angle[COORD_W-1:LOW_W];
        prod_next = h_next * $signed({1'b0, RECIP_45});
    end

    always_comb
    begin
        q_s = prod_reg[P_W-1:32];
        r_s = R_W'(h1_reg) - R_W'(q_s) * R_W'(MOD_BASE);
        // quotient is low by one only when h is a negative multiple of 45
        if (r_s >= R_W'(MOD_BASE))
        begin
            digit_next = DIGIT_W'(r_s - R_W'(MOD_BASE));
        end
        else
        begin
            digit_next = DIGIT_W'(r_s);
        end
    end

    always_comb
    begin
        red   = {digit_reg, low2_reg};
        red_s = {1'b0, red};
        if (red <= QUARTER)
        begin
            fold_s    = red_s;
            flip_next = 1'b0;
        end
        else if (red < THREE_Q)
        begin
            fold_s    = red_s - HALF_S;
            flip_next = 1'b1;
        end
        else
        begin
            fold_s    = red_s - FULL_S;
            flip_next = 1'b0;
        end
        z_next = ang_t'(fold_s) <<< SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            h1_reg   <= h_next;
            prod_reg <= prod_next;
            low1_reg <= in_angle[LOW_W-1:0];
            pt1_reg  <= in_pt;
        end
        if (ld2)
        begin
            digit_reg <= digit_next;
            low2_reg  <= low1_reg;
            pt2_reg   <= pt1_reg;
        end
        if (ld3)
        begin
            z_reg    <= z_next;
            flip_reg <= flip_next;
            pt3_reg  <= pt2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_z     = z_reg;
    assign out_flip  = flip_reg;
    assign out_pt    = pt3_reg;

endmodule

>>> rtl/arv3_cordic.sv
//------------------------------------------------------------------------------
// arv3_cordic
// Unrolled CORDIC in rotation mode, one register stage per iteration.
//------------------------------------------------------------------------------
module arv3_cordic
#(
    parameter int STAGES = arv3_pkg::CORDIC_STAGES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  arv3_pkg::ang_t   in_z,
    input  logic             in_flip,
    input  arv3_pkg::point_t in_pt,
    output logic             out_valid,
    input  logic             out_ready,
    output arv3_pkg::trig_t  out_cos,
    output arv3_pkg::trig_t  out_sin,
    output logic             out_flip,
    output arv3_pkg::point_t out_pt
);
    import arv3_pkg::*;

    logic   v_reg    [STAGES];
    logic   ld       [STAGES];
    trig_t  x_reg    [STAGES];
    trig_t  y_reg    [STAGES];
    ang_t   z_reg    [STAGES];
    logic   flip_reg [STAGES];
    point_t pt_reg   [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic   v_in, flip_in;
        trig_t  x_in, y_in, x_next, y_next;
        ang_t   z_in, z_next;
        point_t pt_in;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign x_in    = INV_GAIN;
            assign y_in    = '0;
            assign z_in    = in_z;
            assign flip_in = in_flip;
            assign pt_in   = in_pt;
        end
        else
        begin : g_next
            assign v_in    = v_reg[i-1];
            assign x_in    = x_reg[i-1];
            assign y_in    = y_reg[i-1];
            assign z_in    = z_reg[i-1];
            assign flip_in = flip_reg[i-1];
            assign pt_in   = pt_reg[i-1];
        end

        if (i == STAGES - 1)
        begin : g_ld_last
            assign ld[i] = !v_reg[i] || out_ready;
        end
        else
        begin : g_ld_mid
            assign ld[i] = !v_reg[i] || ld[i+1];
        end

        always_comb
        begin
            if (!z_in[ANG_W-1])
            begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - atan_deg(i);
            end
            else
            begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + atan_deg(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (ld[i])
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[i])
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                flip_reg[i] <= flip_in;
                pt_reg[i]   <= pt_in;
            end
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[STAGES-1];
    assign out_cos   = x_reg[STAGES-1];
    assign out_sin   = y_reg[STAGES-1];
    assign out_flip  = flip_reg[STAGES-1];
    assign out_pt    = pt_reg[STAGES-1];

endmodule

>>> rtl/arv3_rotate.sv
//------------------------------------------------------------------------------
// arv3_rotate
// Operand select, products, then round and saturate into the output register.
//------------------------------------------------------------------------------
module arv3_rotate
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  arv3_pkg::trig_t  in_cos,
    input  arv3_pkg::trig_t  in_sin,
    input  logic             in_flip,
    input  arv3_pkg::point_t in_pt,
    output logic             out_valid,
    input  logic             out_ready,
    output arv3_pkg::coord_t out_x,
    output arv3_pkg::coord_t out_y,
    output arv3_pkg::coord_t out_z,
    output logic             out_sat
);
    import arv3_pkg::*;

    localparam sum_t ROUND = sum_t'(1) <<< (TRIG_SHIFT - 1);

    function automatic logic clip_hit(input wide_t v);
        return !((v[WIDE_W-1:COORD_W-1] == '0) || (v[WIDE_W-1:COORD_W-1] == '1));
    endfunction

    function automatic coord_t clip_val(input wide_t v);
        coord_t res;
        if (!clip_hit(v))
        begin
            res = v[COORD_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            res = COORD_MIN;
        end
        else
        begin
            res = COORD_MAX;
        end
        return res;
    endfunction

    logic ld_a, ld_b, ld_c;
    logic va_reg, vb_reg, vc_reg;

    // stage A
    trig_t  c_next, s_next, c_reg, s_reg;
    coord_t a_next, b_next, a_reg, b_reg;
    point_t pta_reg;

    // stage B
    prod_t  pac_next, pbs_next, pas_next, pbc_next;
    prod_t  pac_reg, pbs_reg, pas_reg, pbc_reg;
    point_t ptb_reg;

    // stage C (output register)
    sum_t   sum1, sum2;
    wide_t  w1, w2;
    coord_t r1, r2;
    logic   hit;
    coord_t x_next, y_next, z_next, x_reg, y_reg, z_reg;
    logic   sat_next, sat_reg;

    assign ld_c     = !vc_reg || out_ready;
    assign ld_b     = !vb_reg || ld_c;
    assign ld_a     = !va_reg || ld_b;
    assign in_ready = ld_a;

    always_comb
    begin
        c_next = in_flip ? -in_cos : in_cos;
        s_next = in_flip ? -in_sin : in_sin;
        case (in_pt.axis)
            AXIS_X:
            begin
                a_next = in_pt.y;
                b_next = in_pt.z;
            end
            AXIS_Y:
            begin
                a_next = in_pt.x;
                b_next = in_pt.z;
            end
            default:
            begin
                a_next = in_pt.x;
                b_next = in_pt.y;
            end
        endcase
    end

    always_comb
    begin
        pac_next = a_reg * c_reg;
        pbs_next = b_reg * s_reg;
        pas_next = a_reg * s_reg;
        pbc_next = b_reg * c_reg;
    end

    always_comb
    begin
        sum1 = sum_t'(pac_reg) - sum_t'(pbs_reg) + ROUND;
        sum2 = sum_t'(pas_reg) + sum_t'(pbc_reg) + ROUND;
        w1   = sum1[SUM_W-1:TRIG_SHIFT];
        w2   = sum2[SUM_W-1:TRIG_SHIFT];
        r1   = clip_val(w1);
        r2   = clip_val(w2);
        hit  = clip_hit(w1) || clip_hit(w2);
        unique case (ptb_reg.axis)
            AXIS_X:
            begin
                x_next   = ptb_reg.x;
                y_next   = r1;
                z_next   = r2;
                sat_next = hit;
            end
            AXIS_Y:
            begin
                x_next   = r1;
                y_next   = ptb_reg.y;
                z_next   = r2;
                sat_next = hit;
            end
            AXIS_Z:
            begin
                x_next   = r1;
                y_next   = r2;
                z_next   = ptb_reg.z;
                sat_next = hit;
            end
            AXIS_NONE:
            begin
                x_next   = ptb_reg.x;
                y_next   = ptb_reg.y;
                z_next   = ptb_reg.z;
                sat_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (ld_a) va_reg <= in_valid;
            if (ld_b) vb_reg <= va_reg;
            if (ld_c) vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_a)
        begin
            c_reg   <= c_next;
            s_reg   <= s_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
            pta_reg <= in_pt;
        end
        if (ld_b)
        begin
            pac_reg <= pac_next;
            pbs_reg <= pbs_next;
            pas_reg <= pas_next;
            pbc_reg <= pbc_next;
            ptb_reg <= pta_reg;
        end
        if (ld_c)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_sat   = sat_reg;

endmodule

>>> rtl/axis_rotate_vector3.sv
//------------------------------------------------------------------------------
// axis_rotate_vector3
// Rotates a 3D point about the X, Y or Z axis by an angle given in degrees.
//------------------------------------------------------------------------------
// Takes one word per clock and returns one word per clock for a stream of
// independent points while the output side is not stalled. The pipeline runs
// angle reduction (reciprocal multiply, residue modulo 45, fold into
// [-90, 90] degrees), a register stage for each CORDIC iteration, then
// operand select, the four 32x33 products, and round/saturate into the output
// register. Every stage carries its own valid bit and only holds when the
// stage after it is full and stalled, so bubbles are squeezed out and a new
// word is taken while a finished result still waits on the output side.
// Axis code 3 passes the point through untouched with the flag clear; for the
// other codes the coordinate on the rotation axis passes through, and the
// saturation flag is set if either rotated coordinate was clipped to 32 bits.
// A zero angle still goes through CORDIC, so small CORDIC error may show.
//------------------------------------------------------------------------------
module axis_rotate_vector3
#(
    parameter int FRAC_BITS     = arv3_pkg::FRAC_BITS_DEF,     // angle fraction bits
    parameter int CORDIC_STAGES = arv3_pkg::CORDIC_STAGES_DEF  // 8 to 24
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // in_x, in_y, in_z, angle_deg (32 bits each)
    input  logic [1:0]   s_axis_tuser,   // axis_sel

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // out_x, out_y, out_z (32 bits each)
    output logic [0:0]   m_axis_tuser    // saturated
);
    import arv3_pkg::*;

    point_t in_pt;
    coord_t in_angle;

    // angle reduction -> CORDIC
    logic   ang_valid, ang_ready, ang_flip;
    ang_t   ang_z;
    point_t ang_pt;

    // CORDIC -> rotate
    logic   cor_valid, cor_ready, cor_flip;
    trig_t  cor_cos, cor_sin;
    point_t cor_pt;

    coord_t res_x, res_y, res_z;
    logic   res_sat;

    // unpack the slave word
    assign in_pt.x    = s_axis_tdata[31:0];
    assign in_pt.y    = s_axis_tdata[63:32];
    assign in_pt.z    = s_axis_tdata[95:64];
    assign in_pt.axis = axis_t'(s_axis_tuser);
    assign in_angle   = s_axis_tdata[127:96];

    arv3_angle
    #(
        .FRAC_BITS (FRAC_BITS)
    )
    u_angle
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_angle  (in_angle),
        .in_pt     (in_pt),
        .out_valid (ang_valid),
        .out_ready (ang_ready),
        .out_z     (ang_z),
        .out_flip  (ang_flip),
        .out_pt    (ang_pt)
    );

    arv3_cordic
    #(
        .STAGES (CORDIC_STAGES)
    )
    u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ang_valid),
        .in_ready  (ang_ready),
        .in_z      (ang_z),
        .in_flip   (ang_flip),
        .in_pt     (ang_pt),
        .out_valid (cor_valid),
        .out_ready (cor_ready),
        .out_cos   (cor_cos),
        .out_sin   (cor_sin),
        .out_flip  (cor_flip),
        .out_pt    (cor_pt)
    );

    arv3_rotate u_rotate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cor_valid),
        .in_ready  (cor_ready),
        .in_cos    (cor_cos),
        .in_sin    (cor_sin),
        .in_flip   (cor_flip),
        .in_pt     (cor_pt),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_x     (res_x),
        .out_y     (res_y),
        .out_z     (res_z),
        .out_sat   (res_sat)
    );

    // pack the master word
    assign m_axis_tdata = {res_z, res_y, res_x};
    assign m_axis_tuser = res_sat;

endmodule

>>> rtl/arv3_checker.sv
//------------------------------------------------------------------------------
// arv3_checker
// Port-level checks for axis_rotate_vector3, bound to the top level.
//------------------------------------------------------------------------------
module arv3_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [127:0] s_axis_tdata,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // with the output side free, nothing in the pipe can hold the input
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled with output side free");

    // a clipped word has at least one coordinate at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[31:0]  == 32'h7fff_ffff) || (m_axis_tdata[31:0]  == 32'h8000_0000) ||
            (m_axis_tdata[63:32] == 32'h7fff_ffff) || (m_axis_tdata[63:32] == 32'h8000_0000) ||
            (m_axis_tdata[95:64] == 32'h7fff_ffff) || (m_axis_tdata[95:64] == 32'h8000_0000))
        else $error("saturation flag without a clipped coordinate");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

bind axis_rotate_vector3 arv3_checker u_arv3_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
